// ===== hdl/cst_pkg.sv =====
// shared types and constants for the sparse matrix transpose block
// no dependencies, compiled first
package cst_pkg;

    // default sizes, top level parameters take these
    localparam int MAX_DIM_DEF = 1024;
    localparam int MAX_NNZ_DEF = 4096;

    // fixed field widths
    localparam int FUNC_W = 1;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;
    localparam int CFG_W  = 11;
    localparam int POS_W  = 13;
    localparam int VAL_W  = 13;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // request function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // result kinds
    localparam logic KIND_OFFSET = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_PREFIX,
        ST_SCATTER,
        ST_DRAIN
    } t_state;

    // readout item waiting on memory data
    typedef struct packed {
        logic             kind;
        logic             zero;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             range_err;
        logic             ovf;
    } t_pend_item;

endpackage

// ===== hdl/cst_if.sv =====
// request and result channels of the sparse matrix transpose block
// depends on cst_pkg
interface cst_req_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [cst_pkg::ROW_W-1:0] row;
    logic [cst_pkg::COL_W-1:0] col;

    modport source (output valid, output func, output row, output col, input ready);
    modport sink   (input valid, input func, input row, input col, output ready);
endinterface

interface cst_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [cst_pkg::POS_W-1:0] position;
    logic [cst_pkg::VAL_W-1:0] value;
    logic                      last;
    logic                      range_error;
    logic                      overflow;

    modport source (output valid, output kind, output position, output value,
                    output last, output range_error, output overflow, input ready);
    modport sink   (input valid, input kind, input position, input value,
                    input last, input range_error, input overflow, output ready);
endinterface

// ===== hdl/csr_sparse_transpose_top.sv =====
// top level of the sparse matrix transpose block: sequencer and both memories
// depends on cst_pkg, cst_if and cst_out_stage
//
//  channel   direction  handshake            payload
//  i_req     in         valid / ready        func, row, col
//  o_rsp     out        valid / ready        kind, position, value, last, range_error, overflow
//  apb       in         psel/penable/pready  paddr, pwdata, prdata (num_rows at 0, num_cols at 4)
//
// loads and readout fetches are taken one per cycle while no fetch result is held by the sink;
// a fetch result passes the memory read register, then the result register
// the first fetch starts the build pass: prefix over the column counts, then the scatter
// of all entries, bound by the single read and write port of the column memory; requests
// wait during that pass
// after reset and after the last readout item a clearing pass zeroes all MAX_DIM + 1 slots
// of the column memory; requests wait, configuration writes are taken
// a fetch result that the sink stalls holds the pending stage and stops new requests
module csr_sparse_transpose_top #(
    parameter int MAX_DIM = cst_pkg::MAX_DIM_DEF,
    parameter int MAX_NNZ = cst_pkg::MAX_NNZ_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cst_req_if.sink                    i_req,
    cst_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cst_pkg::APB_AW-1:0] paddr,
    input  logic [cst_pkg::APB_DW-1:0] pwdata,
    output logic [cst_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    // column memory: counts during loading, running ends after the build
    localparam int SLOTS = MAX_DIM + 1;
    localparam int SAW   = $clog2(MAX_DIM + 1);
    localparam int TW    = $clog2(MAX_NNZ + 1);
    // entry memory: loaded entries in the lower half, transposed rows in the upper half
    localparam int DDEPTH = 2 * MAX_NNZ;
    localparam int DAW    = $clog2(2 * MAX_NNZ);
    localparam int DW     = cst_pkg::ROW_W + cst_pkg::COL_W;
    localparam int RW     = $clog2(MAX_DIM + MAX_NNZ + 1);
    localparam logic [DAW-1:0] ROWS_BASE = DAW'(MAX_NNZ);

    cst_pkg::t_state r_state, n_state;

    logic [cst_pkg::CFG_W-1:0] r_num_rows;
    logic [cst_pkg::CFG_W-1:0] r_num_cols;
    logic [SAW-1:0]            eff_rows;
    logic [SAW-1:0]            eff_cols;

    logic [TW-1:0]  r_total;
    logic [1:0]     r_flags;
    logic [RW-1:0]  r_ri;
    logic           r_first;
    logic [SAW-1:0] r_idx;
    logic           r_pv;
    logic [SAW-1:0] r_paddr;
    logic [TW-1:0]  r_run;
    logic [TW-1:0]  r_sk;
    logic           r_sa_v;
    logic           r_sb_v;
    logic [cst_pkg::ROW_W-1:0] r_sb_row;
    logic [SAW-1:0] r_sb_col;

    // pending stage: a load finishing its count update, or a fetch waiting for data
    logic                r_p_v;
    logic                r_p_load;
    logic [SAW-1:0]      r_p_col;
    cst_pkg::t_pend_item r_p;

    // memories and their ports
    logic [TW-1:0]  r_slot_mem [SLOTS];
    logic [TW-1:0]  r_slot_q;
    logic           slot_re, slot_we;
    logic [SAW-1:0] slot_raddr, slot_waddr;
    logic [TW-1:0]  slot_wdata;
    logic [DW-1:0]  r_data_mem [DDEPTH];
    logic [DW-1:0]  r_data_q;
    logic           data_re, data_we;
    logic [DAW-1:0] data_raddr, data_waddr;
    logic [DW-1:0]  data_wdata;

    // forwarding for back-to-back updates of one column
    logic          r_hit;
    logic [TW-1:0] r_fwd;
    logic [TW-1:0] base;

    logic req_hs, ld_acc, fe_acc, ld_in, ld_bad, full, ld_ok;
    logic take, p_adv, p_free;
    logic pf_rd, pf_done, sc_rd, sa_hit, sc_done, clr_done;
    logic iss, ri_zero, ri_off, ri_last;
    logic [RW-1:0] ri_pos;
    logic [cst_pkg::COL_W-1:0] sa_col;
    logic [cst_pkg::ROW_W-1:0] sa_row;
    logic cfg_wr;

    // register values above the maximum saturate
    assign eff_rows = (32'(r_num_rows) > 32'(MAX_DIM)) ? SAW'(MAX_DIM) : SAW'(r_num_rows);
    assign eff_cols = (32'(r_num_cols) > 32'(MAX_DIM)) ? SAW'(MAX_DIM) : SAW'(r_num_cols);

    assign base = r_hit ? r_fwd : r_slot_q;

    assign req_hs = i_req.valid && i_req.ready;
    assign ld_acc = req_hs && (i_req.func == cst_pkg::FUNC_LOAD);
    assign fe_acc = req_hs && (i_req.func == cst_pkg::FUNC_FETCH);
    assign ld_in  = ld_acc && (r_state == cst_pkg::ST_LOAD);
    assign ld_bad = (32'(i_req.row) >= 32'(eff_rows)) || (32'(i_req.col) >= 32'(eff_cols));
    assign full   = (r_total == TW'(MAX_NNZ));
    assign ld_ok  = ld_in && !ld_bad && !full;

    assign p_adv  = r_p_v && (r_p_load || take);
    assign p_free = !r_p_v || p_adv;

    // build pass
    assign pf_rd   = (r_state == cst_pkg::ST_PREFIX) && (r_idx < eff_cols);
    assign pf_done = (r_state == cst_pkg::ST_PREFIX) && !pf_rd && !r_pv;
    assign sc_rd   = (r_state == cst_pkg::ST_SCATTER) && (r_sk < r_total);
    assign sa_col  = r_data_q[cst_pkg::COL_W-1:0];
    assign sa_row  = r_data_q[DW-1:cst_pkg::COL_W];
    // entries of columns cut off by a smaller num_cols are skipped
    assign sa_hit  = r_sa_v && (32'(sa_col) < 32'(eff_cols));
    assign sc_done = (r_state == cst_pkg::ST_SCATTER) && !sc_rd && !r_sa_v && !r_sb_v;
    assign clr_done = (r_state == cst_pkg::ST_CLEAR) && (r_idx == SAW'(MAX_DIM));

    // readout decode: offsets first, then transposed rows
    assign iss     = (r_state == cst_pkg::ST_DRAIN) && (fe_acc || (r_first && p_free));
    assign ri_zero = (r_ri == '0);
    assign ri_off  = (r_ri <= RW'(eff_cols));
    assign ri_pos  = r_ri - RW'(eff_cols) - RW'(1);
    assign ri_last = (r_ri >= (RW'(eff_cols) + RW'(r_total)));

    // next state and request ready
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        case (r_state)
            cst_pkg::ST_CLEAR: begin
                if (clr_done) begin
                    n_state = cst_pkg::ST_LOAD;
                end
            end
            cst_pkg::ST_LOAD: begin
                i_req.ready = p_free;
                if (fe_acc) begin
                    n_state = cst_pkg::ST_PREFIX;
                end
            end
            cst_pkg::ST_PREFIX: begin
                if (pf_done) begin
                    n_state = cst_pkg::ST_SCATTER;
                end
            end
            cst_pkg::ST_SCATTER: begin
                if (sc_done) begin
                    n_state = cst_pkg::ST_DRAIN;
                end
            end
            cst_pkg::ST_DRAIN: begin
                i_req.ready = !r_first && p_free;
                if (iss && ri_last) begin
                    n_state = cst_pkg::ST_CLEAR;
                end
            end
            default: begin
                n_state = cst_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cst_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // column memory ports; the users are apart by state
    always_comb begin
        slot_re    = 1'b0;
        slot_raddr = '0;
        if (ld_ok) begin
            slot_re    = 1'b1;
            slot_raddr = SAW'(i_req.col);
        end else if (pf_rd) begin
            slot_re    = 1'b1;
            slot_raddr = r_idx;
        end else if (sa_hit) begin
            slot_re    = 1'b1;
            slot_raddr = SAW'(sa_col);
        end else if (iss && !ri_zero && ri_off) begin
            // offset p is the end of column p-1
            slot_re    = 1'b1;
            slot_raddr = SAW'(r_ri - RW'(1));
        end
    end

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        if (r_state == cst_pkg::ST_CLEAR) begin
            slot_we    = 1'b1;
            slot_waddr = r_idx;
        end else if (r_p_v && r_p_load) begin
            slot_we    = 1'b1;
            slot_waddr = r_p_col;
            slot_wdata = base + TW'(1);
        end else if (r_pv) begin
            slot_we    = 1'b1;
            slot_waddr = r_paddr;
            slot_wdata = r_run;
        end else if (r_sb_v) begin
            slot_we    = 1'b1;
            slot_waddr = r_sb_col;
            slot_wdata = base + TW'(1);
        end
    end

    // entry memory ports
    always_comb begin
        data_re    = 1'b0;
        data_raddr = '0;
        if (sc_rd) begin
            data_re    = 1'b1;
            data_raddr = DAW'(r_sk);
        end else if (iss && !ri_off) begin
            data_re    = 1'b1;
            data_raddr = ROWS_BASE + DAW'(ri_pos);
        end
    end

    always_comb begin
        data_we    = 1'b0;
        data_waddr = '0;
        data_wdata = '0;
        if (ld_ok) begin
            data_we    = 1'b1;
            data_waddr = DAW'(r_total);
            data_wdata = {i_req.row, i_req.col};
        end else if (r_sb_v) begin
            data_we    = 1'b1;
            data_waddr = ROWS_BASE + DAW'(base);
            data_wdata = DW'(r_sb_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            r_slot_q <= r_slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            r_data_mem[data_waddr] <= data_wdata;
        end
        if (data_re) begin
            r_data_q <= r_data_mem[data_raddr];
        end
    end

    // a read that meets a write of the same column takes the written value next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (slot_re) begin
            r_hit <= slot_we && (slot_waddr == slot_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_re) begin
            r_fwd <= slot_wdata;
        end
    end

    // sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_sa_v  <= 1'b0;
            r_sb_v  <= 1'b0;
            r_first <= 1'b0;
            r_ri    <= '0;
            r_total <= '0;
            r_flags <= '0;
            r_sk    <= '0;
            r_run   <= '0;
        end else begin
            if (r_state == cst_pkg::ST_CLEAR) begin
                r_idx <= clr_done ? '0 : r_idx + SAW'(1);
            end else if (pf_rd) begin
                r_idx <= r_idx + SAW'(1);
            end else if (iss && ri_last) begin
                r_idx <= '0;
            end

            // prefix: each column gets the sum of the ones before it
            r_pv <= pf_rd;
            if (fe_acc && (r_state == cst_pkg::ST_LOAD)) begin
                r_run <= '0;
            end else if (r_pv) begin
                r_run <= r_run + r_slot_q;
            end

            // scatter: entry read, column read, then row write and column bump
            if (pf_done) begin
                r_sk <= '0;
            end else if (sc_rd) begin
                r_sk <= r_sk + TW'(1);
            end
            r_sa_v <= sc_rd;
            r_sb_v <= sa_hit;

            if (sc_done) begin
                r_first <= 1'b1;
            end else if (iss) begin
                r_first <= 1'b0;
            end

            if (iss) begin
                r_ri <= ri_last ? '0 : r_ri + RW'(1);
            end

            if (iss && ri_last) begin
                r_total <= '0;
                r_flags <= '0;
            end else begin
                if (ld_ok) begin
                    r_total <= r_total + TW'(1);
                end
                if (ld_in && ld_bad) begin
                    r_flags[0] <= 1'b1;
                end
                if (ld_in && !ld_bad && full) begin
                    r_flags[1] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr  <= r_idx;
        r_sb_row <= sa_row;
        r_sb_col <= SAW'(sa_col);
    end

    // pending stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v    <= 1'b0;
            r_p_load <= 1'b0;
        end else if (iss) begin
            r_p_v    <= 1'b1;
            r_p_load <= 1'b0;
        end else if (ld_ok) begin
            r_p_v    <= 1'b1;
            r_p_load <= 1'b1;
        end else if (p_adv) begin
            r_p_v    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_ok) begin
            r_p_col <= SAW'(i_req.col);
        end
        if (iss) begin
            r_p.kind      <= ri_off ? cst_pkg::KIND_OFFSET : cst_pkg::KIND_ROW;
            r_p.zero      <= ri_zero;
            r_p.pos       <= ri_off ? cst_pkg::POS_W'(r_ri) : cst_pkg::POS_W'(ri_pos);
            r_p.last      <= ri_last;
            r_p.range_err <= r_flags[0];
            r_p.ovf       <= r_flags[1];
        end
    end

    cst_out_stage #(
        .SLOT_W (TW)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pend_v (r_p_v && !r_p_load),
        .i_pend   (r_p),
        .i_slot_q (r_slot_q),
        .i_data_q (r_data_q[cst_pkg::ROW_W-1:0]),
        .o_take   (take),
        .o_rsp    (o_rsp)
    );

    // configuration registers, frozen from the first fetch to the last readout item
    assign cfg_wr = psel && penable && pwrite &&
                    ((r_state == cst_pkg::ST_CLEAR) || (r_state == cst_pkg::ST_LOAD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= cst_pkg::CFG_W'(1024);
            r_num_cols <= cst_pkg::CFG_W'(1024);
        end else if (cfg_wr) begin
            if (paddr[cst_pkg::REG_SEL_BIT] == cst_pkg::REG_NUM_COLS) begin
                r_num_cols <= pwdata[cst_pkg::CFG_W-1:0];
            end else begin
                r_num_rows <= pwdata[cst_pkg::CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[cst_pkg::REG_SEL_BIT] == cst_pkg::REG_NUM_COLS) ?
                    cst_pkg::APB_DW'(r_num_cols) : cst_pkg::APB_DW'(r_num_rows);
    assign pready = 1'b1;

    // a fetch stalled by the sink keeps its pending item untouched
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_v && !r_p_load && !take |=> r_p_v && !r_p_load && $stable(r_p))
        else $error("pending fetch changed while stalled");

    // the store never counts more entries than it holds
    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(MAX_NNZ))
        else $error("entry total above capacity");

    // scatter destinations stay inside the loaded entries
    a_scatter_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sb_v |-> base < r_total)
        else $error("scatter destination out of range");

    // only one user drives the column write port
    a_slot_wr_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_state == cst_pkg::ST_CLEAR, r_p_v && r_p_load, r_pv, r_sb_v}) <= 1)
        else $error("column memory write conflict");

    // the last readout item empties the store and starts clearing
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iss && ri_last |=> r_state == cst_pkg::ST_CLEAR && r_total == '0 && r_flags == '0)
        else $error("store not reset after last item");

endmodule

// ===== hdl/cst_out_stage.sv =====
// result register: picks the readout value from memory data and holds it for the sink
// depends on cst_pkg and cst_if
module cst_out_stage #(
    parameter int SLOT_W = $clog2(cst_pkg::MAX_NNZ_DEF + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_pend_v,
    input  cst_pkg::t_pend_item       i_pend,
    input  logic [SLOT_W-1:0]         i_slot_q,
    input  logic [cst_pkg::ROW_W-1:0] i_data_q,
    output logic                      o_take,
    cst_rsp_if.source                 o_rsp
);

    logic                      r_v;
    logic                      r_kind;
    logic [cst_pkg::POS_W-1:0] r_pos;
    logic [cst_pkg::VAL_W-1:0] r_val;
    logic                      r_last;
    logic                      r_range_err;
    logic                      r_ovf;
    logic [cst_pkg::VAL_W-1:0] n_val;

    assign o_take = !r_v || o_rsp.ready;

    always_comb begin
        if (i_pend.kind == cst_pkg::KIND_OFFSET) begin
            n_val = i_pend.zero ? '0 : cst_pkg::VAL_W'(i_slot_q);
        end else begin
            n_val = cst_pkg::VAL_W'(i_data_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_pend_v && o_take) begin
            r_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pend_v && o_take) begin
            r_kind      <= i_pend.kind;
            r_pos       <= i_pend.pos;
            r_val       <= n_val;
            r_last      <= i_pend.last;
            r_range_err <= i_pend.range_err;
            r_ovf       <= i_pend.ovf;
        end
    end

    assign o_rsp.valid       = r_v;
    assign o_rsp.kind        = r_kind;
    assign o_rsp.position    = r_pos;
    assign o_rsp.value       = r_val;
    assign o_rsp.last        = r_last;
    assign o_rsp.range_error = r_range_err;
    assign o_rsp.overflow    = r_ovf;

endmodule
